[src/pia_pkg.sv]
// Package with the shared types, constants and helpers of the positional insert array.
`default_nettype none

package pia_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Cell index width and fill count width (the count must also hold CAPACITY).
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_elem;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHOW   = 2'd2,
        OP_COUNT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [3:0]         index;
        logic signed [31:0] element;
        logic [4:0]         count;
        logic               last;
    } t_result;

    // Control broadcast from the sequencer to every cell in the row.
    typedef struct packed {
        logic             ins;      // write value at pos, move later cells up
        logic             rot;      // move every stored cell one place down
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] fill;
        logic [IDX_W-1:0] rot_end;  // highest occupied cell during a rotation
        t_elem            value;
        t_elem            head;     // cell 0 contents, wrapped to rot_end
    } t_cell_ctl;

    // Sign-extend or truncate an input value to the stored width.
    function automatic t_elem to_elem(input logic signed [31:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // Sign-extend or truncate a stored element to the result field.
    function automatic logic signed [31:0] to_field(input t_elem e);
        return 32'(e);
    endfunction

endpackage

`default_nettype wire

[src/pia_cell.sv]
// One storage cell of the insert array row.
`default_nettype none

module pia_cell
    import pia_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_cell_ctl  i_ctl,
    input  wire t_elem      i_lower,
    input  wire t_elem      i_upper,
    output t_elem           o_data
);

    t_elem r_data;
    t_elem n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_index == i_ctl.pos) begin
                n_data = i_ctl.value;
            end else if ((i_index > i_ctl.pos) && (CNT_W'(i_index) <= i_ctl.fill)) begin
                n_data = i_lower;
            end
        end else if (i_ctl.rot) begin
            // The head wraps round to the top so that a full pass restores the order.
            if (i_index == i_ctl.rot_end) begin
                n_data = i_ctl.head;
            end else if (i_index < i_ctl.rot_end) begin
                n_data = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[src/positional_insert_array.sv]
// Top level of the positional insert array: sequencer, result register and the cell row.
//
//  channel | ports                      | handshake
//  --------+----------------------------+---------------------------------------
//  command | i_cmd                      | taken when start is high and busy low
//  result  | o_result                   | valid for one cycle while o_strobe high
//
// Append, insert and count complete when accepted; their result appears the cycle after.
// Display uses the accepting cycle, then sends one beat per stored element (a single
// empty-status beat if the array is empty): the elements rotate down the cell row and
// are read from cell 0, busy staying high until the last beat has been launched. Reset
// clears the fill count and the sequencer; cell contents are undefined until
// written. The receiver cannot stall.
`default_nettype none

module positional_insert_array
    import pia_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_strobe,
    output t_result   o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SHOW = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_strobe, n_strobe;
    t_result          r_out, n_out;
    t_cell_ctl        ctl;
    t_elem            cell_data [CAPACITY];
    logic             accept;
    logic             full;
    logic             pos_ok;
    logic             show_last;

    assign accept    = start && (r_state == S_IDLE);
    assign full      = (r_fill == CNT_W'(CAPACITY));
    assign pos_ok    = ({{(CNT_W + 1){1'b0}}, i_cmd.position} <= (CNT_W + 6)'(r_fill));
    assign show_last = (CNT_W'(r_idx) == (r_fill - CNT_W'(1)));

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_out    = '{status: ST_OK, index: 4'd0, element: 32'sd0,
                    count: 5'(r_fill), last: 1'b1};
        ctl      = '{ins: 1'b0, rot: 1'b0, pos: IDX_W'(i_cmd.position), fill: r_fill,
                    rot_end: IDX_W'(r_fill - CNT_W'(1)), value: to_elem(i_cmd.value),
                    head: cell_data[0]};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    unique case (i_cmd.op)
                        OP_APPEND: begin
                            if (full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ctl.ins     = 1'b1;
                                ctl.pos     = IDX_W'(r_fill);
                                n_fill      = r_fill + CNT_W'(1);
                                n_out.index = 4'(r_fill);
                                n_out.count = 5'(n_fill);
                            end
                        end
                        OP_INSERT: begin
                            if (!pos_ok) begin
                                n_out.status = ST_BAD_POS;
                            end else if (full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ctl.ins     = 1'b1;
                                n_fill      = r_fill + CNT_W'(1);
                                n_out.index = 4'(i_cmd.position);
                                n_out.count = 5'(n_fill);
                            end
                        end
                        OP_SHOW: begin
                            if (r_fill == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                // Results come from the rotation; nothing leaves this cycle.
                                n_strobe = 1'b0;
                                n_idx    = '0;
                                n_state  = S_SHOW;
                            end
                        end
                        OP_COUNT: begin
                            n_out.status = ST_OK;
                        end
                        default: begin
                            n_out.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SHOW: begin
                ctl.rot       = 1'b1;
                n_strobe      = 1'b1;
                n_out.index   = 4'(r_idx);
                n_out.element = to_field(cell_data[0]);
                n_out.last    = show_last;
                n_idx         = r_idx + IDX_W'(1);
                if (show_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        pia_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (ctl),
            .i_lower (cell_data[(g == 0) ? 0 : g - 1]),
            .i_upper (cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (cell_data[g])
        );
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // A display run is delivered as an unbroken burst of beats.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("display run broken");

    // Every accepted command that does not start a display answers in the next cycle.
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("command produced no result");

    // A display pass only runs over a non-empty array.
    a_show_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHOW) |-> (r_fill != '0))
        else $error("display with empty array");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");
`endif

endmodule

`default_nettype wire

[sim/positional_insert_array_tb.sv]
// Self-checking testbench for the positional insert array: directed and random commands.
module positional_insert_array_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pia_pkg::*;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Shadow copy of the array, updated when a command beat is accepted.
    t_elem            shadow_elems [CAPACITY];
    logic [CNT_W-1:0] shadow_fill = '0;
    t_result          expected_beats [$];

    int  mismatch_count   = 0;
    int  items_sent       = 0;
    int  beats_checked    = 0;
    int  full_rejects     = 0;
    int  position_rejects = 0;
    int  displays_sent    = 0;
    bit  steady_burst     = 1'b0;

    always #10 i_clk = ~i_clk;

    positional_insert_array dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic push_beat(input t_status st, input int idx, input logic signed [31:0] elem,
                             input int cnt, input bit last);
        t_result r;
        r.status  = st;
        r.index   = 4'(idx);
        r.element = elem;
        r.count   = 5'(cnt);
        r.last    = last;
        expected_beats.push_back(r);
    endtask

    // Works out the result beats of one accepted command and updates the shadow array.
    task automatic apply_array_op(input t_cmd c);
        int fill;
        fill = int'(shadow_fill);
        case (c.op)
            OP_APPEND: begin
                if (fill >= CAPACITY) begin
                    push_beat(ST_FULL, 0, '0, fill, 1'b1);
                    full_rejects++;
                end else begin
                    shadow_elems[fill] = t_elem'(c.value);
                    shadow_fill = CNT_W'(fill + 1);
                    push_beat(ST_OK, fill, '0, fill + 1, 1'b1);
                end
            end
            OP_INSERT: begin
                // The position check takes priority over the full check.
                if (int'(c.position) > fill) begin
                    push_beat(ST_BAD_POS, 0, '0, fill, 1'b1);
                    position_rejects++;
                end else if (fill >= CAPACITY) begin
                    push_beat(ST_FULL, 0, '0, fill, 1'b1);
                    full_rejects++;
                end else begin
                    for (int i = fill; i > int'(c.position); i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[c.position] = t_elem'(c.value);
                    shadow_fill = CNT_W'(fill + 1);
                    push_beat(ST_OK, int'(c.position), '0, fill + 1, 1'b1);
                end
            end
            OP_SHOW: begin
                displays_sent++;
                if (fill == 0) begin
                    push_beat(ST_EMPTY, 0, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++)
                        push_beat(ST_OK, i, 32'(shadow_elems[i]), fill, (i + 1 == fill));
                end
            end
            default: begin
                push_beat(ST_OK, 0, '0, fill, 1'b1);
            end
        endcase
    endtask

    // Sends one command beat after a random gap (none during a steady burst) and waits until it is taken.
    task automatic send_op(input t_op op, input int pos, input logic signed [31:0] val);
        t_cmd c;
        int   gap;
        c.op       = op;
        c.position = 5'(pos);
        c.value    = val;
        gap = steady_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_array_op(c);
        items_sent++;
        // Now and then switch to a stretch of back-to-back beats.
        if (items_sent % 24 == 0)
            steady_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // One random command; writes are rare so that the array fills slowly.
    task automatic send_random_op();
        int pick;
        int fill;
        fill = int'(shadow_fill);
        pick = $urandom_range(0, 11);
        if (pick == 0)
            send_op(OP_APPEND, $urandom_range(0, 31), random_value());
        else if (pick == 1)
            send_op(OP_INSERT, $urandom_range(0, fill), random_value());
        else if (pick <= 4)
            send_op(OP_INSERT, $urandom_range(fill + 1, 31), random_value());
        else if (pick <= 8)
            send_op(OP_SHOW, $urandom_range(0, 31), random_value());
        else
            send_op(OP_COUNT, $urandom_range(0, 31), random_value());
    endtask

    task automatic test_empty_array();
        send_op(OP_SHOW, 0, '0);
        send_op(OP_COUNT, 31, -32'sd1);
        send_op(OP_INSERT, 1, -32'sd1);
        send_op(OP_INSERT, 31, 32'sh7FFF_FFFF);
    endtask

    task automatic test_ordered_writes();
        send_op(OP_INSERT, 0, 32'sh7FFF_FFFF);
        send_op(OP_APPEND, 31, 32'sh8000_0000);
        send_op(OP_INSERT, 0, -32'sd1);
        send_op(OP_INSERT, 3, 32'sh0000_0000);   // position equal to the fill count
        send_op(OP_INSERT, 1, 32'sh5555_5555);
        send_op(OP_INSERT, 6, 32'shAAAA_AAAA);   // one past the end
        send_op(OP_SHOW, 0, '0);
        send_op(OP_COUNT, 0, '0);
    endtask

    task automatic test_random_fill();
        while (int'(shadow_fill) < CAPACITY)
            send_random_op();
    endtask

    task automatic test_full_array();
        send_op(OP_APPEND, 0, 32'sh1234_5678);
        send_op(OP_INSERT, 16, 32'sh0BAD_F00D);
        send_op(OP_INSERT, 0, -32'sd1);
        send_op(OP_INSERT, 17, 32'sh7FFF_FFFF);   // both faults: position wins
        send_op(OP_INSERT, 31, 32'sh8000_0000);
        send_op(OP_SHOW, 0, '0);
        send_op(OP_COUNT, 0, '0);
    endtask

    task automatic test_random_full(input int total);
        while (items_sent < total)
            send_random_op();
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected (status %0d)",
                                          o_result.status));
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_result.status, want.status));
                if (o_result.index !== want.index)
                    report_mismatch($sformatf("index %0d, expected %0d",
                                              o_result.index, want.index));
                if (o_result.element !== want.element)
                    report_mismatch($sformatf("element %h, expected %h",
                                              o_result.element, want.element));
                if (o_result.count !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              o_result.count, want.count));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              o_result.last, want.last));
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_array();
        test_ordered_writes();
        test_random_fill();
        test_full_array();
        test_random_full(330);
        drain_results();

        $display("Sent %0d commands (%0d displays), checked %0d result beats.",
                 items_sent, displays_sent, beats_checked);
        $display("Rejected: %0d on a full array, %0d on a bad position.",
                 full_rejects, position_rejects);
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d result beats outstanding.", expected_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
